/* rtl/msnp_pkg.sv */
// Shared types and constants for the nearest-source path unit.
// Used by msnp_cell and the top level; depends on nothing else.
package msnp_pkg;

  localparam int NODE_W = 7;
  localparam int DIST_W = 15;
  localparam int ALT_W  = 16;
  localparam logic [DIST_W-1:0] DIST_INF = 15'd23843;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_MARK = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;

  typedef enum logic [2:0] {
    CMD_NOP, CMD_MARK, CMD_INIT, CMD_POP, CMD_RELAX, CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   cnt;
    logic [ALT_W-1:0]    alt;
    logic [NODE_W-1:0]   owner;
  } cmd_t;

  typedef struct packed {
    logic                live;
    logic                found;
    logic [DIST_W-1:0]   dval;
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   owner;
  } tok_t;

  typedef struct packed {
    logic [DIST_W-1:0]   dval;
    logic [NODE_W-1:0]   par;
    logic [NODE_W-1:0]   own;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_INIT, ST_SCAN, ST_POP, ST_LIST,
    ST_WALK_RD, ST_WALK_REL, ST_EMIT
  } state_t;

endpackage

/* rtl/msnp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msnp_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/msnp_cell.sv */
// One node cell: distance, parent, owner, source and popped flags.
// Passes the min-search token and the result record to its neighbor; uses msnp_pkg.
module msnp_cell import msnp_pkg::*; #(
  parameter logic [NODE_W-1:0] CELL_ID = 7'd1
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  logic shift_en,
  input  tok_t tok_in,
  output tok_t tok_out,
  input  rec_t rec_in,
  output rec_t rec_out
);

  logic              src_r;
  logic              popped_r;
  logic [DIST_W-1:0] dist_r;
  logic [NODE_W-1:0] par_r;
  logic [NODE_W-1:0] own_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              hit;
  logic              cand;

  assign hit  = (cmd.node == CELL_ID);
  assign cand = !popped_r && (dist_r < DIST_INF);

  // later cells win ties: larger node number on equal distance
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.live && cand && (!tok_in.found || dist_r <= tok_in.dval)) begin
      tok_nxt.found = 1'b1;
      tok_nxt.dval  = dist_r;
      tok_nxt.node  = CELL_ID;
      tok_nxt.owner = own_r;
    end
  end

  assign tok_out = tok_r;
  assign rec_out = '{dval: dist_r, par: par_r, own: own_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r    <= 1'b0;
      popped_r <= 1'b0;
      tok_r    <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (shift_en) begin
        dist_r <= rec_in.dval;
        par_r  <= rec_in.par;
        own_r  <= rec_in.own;
      end else begin
        unique case (cmd.op)
          CMD_MARK: begin
            if (hit) src_r <= 1'b1;
          end
          CMD_INIT: begin
            popped_r <= 1'b0;
            par_r    <= '0;
            if (src_r && CELL_ID <= cmd.cnt) begin
              dist_r <= '0;
              own_r  <= CELL_ID;
            end else begin
              dist_r <= DIST_INF;
              own_r  <= '0;
            end
          end
          CMD_POP: begin
            if (hit) popped_r <= 1'b1;
          end
          CMD_RELAX: begin
            if (hit) begin
              if (ALT_W'(dist_r) > cmd.alt) begin
                dist_r <= cmd.alt[DIST_W-1:0];
                par_r  <= cmd.src;
                own_r  <= cmd.owner;
              end else if (ALT_W'(dist_r) == cmd.alt && cmd.owner < own_r) begin
                own_r <= cmd.owner;
              end
            end
          end
          CMD_CLEAR: src_r <= 1'b0;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/multi_source_nearest_source_paths_unit.sv */
// Multi-source nearest-source shortest paths over a loaded undirected graph.
// Uses msnp_pkg, msnp_ram and a chain of msnp_cell, one cell per node.
//
// Input requests (valid/ready): add edge, mark source, run. An edge add makes
// two directed appends, each a tail read then a write. A run sets up, then
// for every pop does one scan (the search token walks the cell chain one cell
// a cycle), a list lookup and, per adjacency entry, an edge RAM read, then a
// relax broadcast. A final scan that finds nothing ends the walk. Results then
// leave one per cycle unless out_ready holds them, node 1 to node_count,
// last_result on the final one; the output register holds a result while
// out_ready is low and the chain shifts only when a result is taken. After the
// last result the edge lists and source marks are cleared and a new request
// may enter while that result still waits. cfg writes set node_count
// (saturated to 1..MAX_NODES) and are always ready; write it only while idle.
// Reset: node_count = MAX_NODES, no edges, no sources, no result pending.
module multi_source_nearest_source_paths_unit import msnp_pkg::*; #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [6:0]        in_node_a,
  input  logic [6:0]        in_node_b,
  input  logic [11:0]       in_edge_weight,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        out_node_id,
  output logic [6:0]        out_owner_source,
  output logic [6:0]        out_parent_node,
  output logic [14:0]       out_path_distance,
  output logic              out_last_result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_node_count
);

  localparam int DIR     = 2 * MAX_EDGES;
  localparam int EIDX_W  = $clog2(DIR);
  localparam int FILL_W  = $clog2(DIR + 1);
  localparam int NADDR_W = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 2);
  localparam int EDATA_W = NODE_W + WEIGHT_BITS;

  state_t                 state_r, state_nxt;
  logic [NODE_W-1:0]      ncnt_r;
  logic [FILL_W-1:0]      fill_r;
  logic [MAX_NODES-1:0]   vld_r;
  logic [NODE_W-1:0]      from_r, to_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic                   dir_r;
  logic                   tvld_r;
  logic [CNT_W-1:0]       scan_cnt_r;
  logic [NODE_W-1:0]      u_r;
  logic [DIST_W-1:0]      du_r;
  logic [NODE_W-1:0]      ou_r;
  logic [EIDX_W-1:0]      e_r, tl_r;
  logic [NODE_W-1:0]      emit_i_r;
  cmd_t                   cmd_r, cmd_nxt;
  logic                   shift_en;
  logic                   emit_load;

  logic                   out_vld_r;
  logic [NODE_W-1:0]      out_id_r, out_own_r, out_par_r;
  logic [DIST_W-1:0]      out_dist_r;
  logic                   out_last_r;

  logic                   in_acc;
  logic                   add_ok;
  logic [NADDR_W-1:0]     from_addr, u_addr;
  logic [EIDX_W-1:0]      fill_idx;

  // RAM ports
  logic                   edge_we;
  logic [EDATA_W-1:0]     edge_rdata;
  logic                   next_we;
  logic [EIDX_W-1:0]      next_rdata;
  logic                   head_we;
  logic [EIDX_W-1:0]      head_rdata;
  logic                   tail_we;
  logic [NADDR_W-1:0]     tail_raddr;
  logic [EIDX_W-1:0]      tail_rdata;

  logic [NODE_W-1:0]      rel_v;
  logic [WEIGHT_BITS-1:0] rel_w;
  logic [ALT_W-1:0]       rel_alt;

  tok_t tok [MAX_NODES+1];
  rec_t rec [MAX_NODES+1];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign add_ok    = (in_node_a != '0) && (in_node_a <= NODE_W'(MAX_NODES)) &&
                     (in_node_b != '0) && (in_node_b <= NODE_W'(MAX_NODES)) &&
                     (fill_r <= FILL_W'(DIR - 2));
  assign from_addr = NADDR_W'(from_r - 7'd1);
  assign u_addr    = NADDR_W'(u_r - 7'd1);
  assign fill_idx  = fill_r[EIDX_W-1:0];
  assign rel_v     = edge_rdata[EDATA_W-1:WEIGHT_BITS];
  assign rel_w     = edge_rdata[WEIGHT_BITS-1:0];
  assign rel_alt   = ALT_W'(du_r) + ALT_W'(rel_w);
  assign emit_load = (state_r == ST_EMIT) && (!out_vld_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_ADD && add_ok) state_nxt = ST_ADD_RD;
          else if (in_req_type == REQ_RUN)      state_nxt = ST_INIT;
        end
      end
      ST_ADD_RD:  state_nxt = ST_ADD_WR;
      ST_ADD_WR:  state_nxt = dir_r ? ST_IDLE : ST_ADD_RD;
      ST_INIT:    state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_cnt_r == CNT_W'(MAX_NODES + 1))
          state_nxt = tok[MAX_NODES].found ? ST_POP : ST_EMIT;
      end
      ST_POP:     state_nxt = ST_LIST;
      ST_LIST:    state_nxt = tvld_r ? ST_WALK_RD : ST_SCAN;
      ST_WALK_RD: state_nxt = ST_WALK_REL;
      ST_WALK_REL: state_nxt = (e_r == tl_r) ? ST_SCAN : ST_WALK_RD;
      ST_EMIT: begin
        if (emit_load && emit_i_r == ncnt_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_nxt    = '0;
    cmd_nxt.op = CMD_NOP;
    edge_we    = 1'b0;
    next_we    = 1'b0;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    tail_raddr = from_addr;
    shift_en   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_req_type == REQ_MARK) begin
          cmd_nxt.op   = CMD_MARK;
          cmd_nxt.node = in_node_a;
        end
      end
      ST_ADD_WR: begin
        edge_we = 1'b1;
        next_we = tvld_r;
        head_we = !tvld_r;
        tail_we = 1'b1;
      end
      ST_INIT: begin
        cmd_nxt.op  = CMD_INIT;
        cmd_nxt.cnt = ncnt_r;
      end
      ST_POP: begin
        cmd_nxt.op   = CMD_POP;
        cmd_nxt.node = u_r;
        tail_raddr   = u_addr;
      end
      ST_WALK_REL: begin
        if (rel_v != '0 && rel_v <= ncnt_r) begin
          cmd_nxt.op    = CMD_RELAX;
          cmd_nxt.node  = rel_v;
          cmd_nxt.src   = u_r;
          cmd_nxt.alt   = rel_alt;
          cmd_nxt.owner = ou_r;
        end
      end
      ST_EMIT: begin
        shift_en = emit_load;
        if (emit_load && emit_i_r == ncnt_r) cmd_nxt.op = CMD_CLEAR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ncnt_r     <= NODE_W'(MAX_NODES);
      fill_r     <= '0;
      vld_r      <= '0;
      cmd_r      <= '0;
      out_vld_r  <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_node_count == '0)                         ncnt_r <= 7'd1;
        else if (cfg_node_count > NODE_W'(MAX_NODES))     ncnt_r <= NODE_W'(MAX_NODES);
        else                                              ncnt_r <= cfg_node_count;
      end
      if (state_r == ST_ADD_WR) begin
        fill_r           <= fill_r + 1'b1;
        vld_r[from_addr] <= 1'b1;
      end
      if (state_r == ST_SCAN) scan_cnt_r <= scan_cnt_r + 1'b1;
      else                    scan_cnt_r <= '0;
      if (emit_load) begin
        out_vld_r <= 1'b1;
        if (emit_i_r == ncnt_r) begin
          fill_r <= '0;
          vld_r  <= '0;
        end
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      from_r <= in_node_a;
      to_r   <= in_node_b;
      w_r    <= in_edge_weight[WEIGHT_BITS-1:0];
      dir_r  <= 1'b0;
    end
    if (state_r == ST_ADD_RD) tvld_r <= vld_r[from_addr];
    if (state_r == ST_POP)    tvld_r <= vld_r[u_addr];
    if (state_r == ST_ADD_WR) begin
      // swap ends for the reverse direction
      from_r <= to_r;
      to_r   <= from_r;
      dir_r  <= 1'b1;
    end
    if (state_r == ST_SCAN) begin
      u_r  <= tok[MAX_NODES].node;
      du_r <= tok[MAX_NODES].dval;
      ou_r <= tok[MAX_NODES].owner;
    end
    if (state_r == ST_LIST) begin
      e_r  <= head_rdata;
      tl_r <= tail_rdata;
    end
    if (state_r == ST_WALK_REL) e_r <= next_rdata;
    if (state_r == ST_SCAN) emit_i_r <= 7'd1;
    else if (emit_load)     emit_i_r <= emit_i_r + 7'd1;
    if (emit_load) begin
      out_id_r   <= emit_i_r;
      out_own_r  <= (rec[0].own == emit_i_r) ? '0 : rec[0].own;
      out_par_r  <= rec[0].par;
      out_dist_r <= rec[0].dval;
      out_last_r <= (emit_i_r == ncnt_r);
    end
  end

  assign out_valid         = out_vld_r;
  assign out_node_id       = out_id_r;
  assign out_owner_source  = out_own_r;
  assign out_parent_node   = out_par_r;
  assign out_path_distance = out_dist_r;
  assign out_last_result   = out_last_r;

  msnp_ram #(.W(EDATA_W), .D(DIR)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(fill_idx), .wdata({to_r, w_r}),
    .raddr(e_r), .rdata(edge_rdata)
  );

  msnp_ram #(.W(EIDX_W), .D(DIR)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(tail_rdata), .wdata(fill_idx),
    .raddr(e_r), .rdata(next_rdata)
  );

  msnp_ram #(.W(EIDX_W), .D(MAX_NODES)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(from_addr), .wdata(fill_idx),
    .raddr(u_addr), .rdata(head_rdata)
  );

  msnp_ram #(.W(EIDX_W), .D(MAX_NODES)) u_tail_ram (
    .clk(clk), .we(tail_we), .waddr(from_addr), .wdata(fill_idx),
    .raddr(tail_raddr), .rdata(tail_rdata)
  );

  // inject the search token once pending init/pop/relax commands have landed
  always_comb begin
    tok[0]      = '0;
    tok[0].live = (state_r == ST_SCAN) && (scan_cnt_r == CNT_W'(1));
  end
  assign rec[MAX_NODES] = '0;

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    msnp_cell #(.CELL_ID(NODE_W'(g + 1))) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd_r), .shift_en(shift_en),
      .tok_in(tok[g]), .tok_out(tok[g+1]),
      .rec_in(rec[g+1]), .rec_out(rec[g])
    );
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DIR))
    else $error("edge fill beyond store");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK_REL |-> $past(state_r) == ST_WALK_RD)
    else $error("relax without edge read");

  a_token_end: assert property (@(posedge clk) disable iff (!rst_n)
    tok[MAX_NODES].live |-> state_r == ST_SCAN && scan_cnt_r == CNT_W'(MAX_NODES + 1))
    else $error("search token out of step");
`endif

endmodule
